// ----- rtl/fgd_pkg.sv -----
// Shared types and constants for the Group 3 fax EOL/RTC row deframer.
// Holds the event format passed from the bit scanner to the row builder.
// No dependencies.
package fgd_pkg;

   // Command codes on the request channel.
   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Result kinds on the response channel.
   localparam logic RSP_KIND_ROW     = 1'b0;
   localparam logic RSP_KIND_SUMMARY = 1'b1;

   // Eleven zeros followed by a one make an end-of-line code.
   localparam logic [3:0] EOL_MIN_ZEROS = 4'd11;

   // Bytes appended to every non-empty row.
   localparam logic [7:0] EOL_FIRST_BYTE = 8'h00;
   localparam logic [7:0] EOL_CODE_1D    = 8'h01;
   localparam logic [7:0] EOL_CODE_2D    = 8'h02;

   localparam logic [15:0] ROW_COUNT_MAX  = 16'hFFFF;
   localparam logic [23:0] BYTE_COUNT_MAX = 24'hFFFFFF;

   localparam int EVQ_DEPTH = 4;

   // Events from the scanner: a short run to pack, a row end, or a page end.
   typedef enum logic [1:0] {
      EV_RUN,
      EV_EOL,
      EV_RTC,
      EV_EOD
   } ev_kind_type;

   // For EV_RUN the argument is the run length including its closing one;
   // for EV_EOL it is the second EOL byte.
   typedef struct packed {
      ev_kind_type kind;
      logic [3:0]  arg;
   } evq_entry_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_RUN,
      BK_PAD,
      BK_EOL_LO,
      BK_EOL_HI,
      BK_FLUSH,
      BK_DRAIN_RD,
      BK_DRAIN_WAIT,
      BK_SUM
   } back_state_type;

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7 - i] = v[i];
      end
      return r;
   endfunction

endpackage

// ----- rtl/fgd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fgd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/fgd_front.sv -----
// Bit scanner: accepts request beats and splits the line bits into runs,
// row ends and page ends, pushed as events into the queue. Uses fgd_pkg.
module fgd_front import fgd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          two_d_mode,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_cmd,
   input  logic [7:0]    req_data_byte,
   input  logic          evq_full,
   output logic          evq_push,
   output evq_entry_type evq_data
);

   logic       busy_ff, busy_in;
   logic       cmd_ff, cmd_in;
   logic [7:0] byte_ff, byte_in;
   logic [2:0] idx_ff, idx_in;
   logic [3:0] zero_run_ff, zero_run_in;
   logic       tag_pending_ff, tag_pending_in;
   logic       row_has_data_ff, row_has_data_in;
   logic [1:0] empty_eol_ff, empty_eol_in;

   logic          step;
   logic          done;
   logic          bit_val;
   logic          eol_now;
   logic          eol_tag;
   evq_entry_type ev;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         zero_run_ff     <= '0;
         tag_pending_ff  <= 1'b0;
         row_has_data_ff <= 1'b0;
         empty_eol_ff    <= '0;
      end else begin
         busy_ff         <= busy_in;
         zero_run_ff     <= zero_run_in;
         tag_pending_ff  <= tag_pending_in;
         row_has_data_ff <= row_has_data_in;
         empty_eol_ff    <= empty_eol_in;
      end
      cmd_ff  <= cmd_in;
      byte_ff <= byte_in;
      idx_ff  <= idx_in;
   end

   always_comb begin
      busy_in         = busy_ff;
      cmd_in          = cmd_ff;
      byte_in         = byte_ff;
      idx_in          = idx_ff;
      zero_run_in     = zero_run_ff;
      tag_pending_in  = tag_pending_ff;
      row_has_data_in = row_has_data_ff;
      empty_eol_in    = empty_eol_ff;
      ev              = '{kind: EV_RUN, arg: 4'd0};
      evq_push        = 1'b0;
      done            = 1'b0;
      eol_now         = 1'b0;
      eol_tag         = 1'b0;

      // One line bit per cycle; every bit needs a free queue slot.
      step    = busy_ff && !evq_full;
      bit_val = byte_ff[idx_ff];

      if (step) begin
         done = (idx_ff == 3'd7);
         if (cmd_ff == CMD_END) begin
            evq_push        = 1'b1;
            ev.kind         = EV_EOD;
            zero_run_in     = '0;
            tag_pending_in  = 1'b0;
            row_has_data_in = 1'b0;
            empty_eol_in    = '0;
            done            = 1'b1;
         end else if (tag_pending_ff) begin
            tag_pending_in = 1'b0;
            eol_now        = 1'b1;
            eol_tag        = bit_val;
         end else if (!bit_val) begin
            if (zero_run_ff < EOL_MIN_ZEROS) begin
               zero_run_in = zero_run_ff + 4'd1;
            end
         end else if (zero_run_ff >= EOL_MIN_ZEROS) begin
            zero_run_in = '0;
            if (two_d_mode) begin
               tag_pending_in = 1'b1;
            end else begin
               eol_now = 1'b1;
            end
         end else begin
            evq_push        = 1'b1;
            ev.kind         = EV_RUN;
            ev.arg          = zero_run_ff + 4'd1;
            zero_run_in     = '0;
            row_has_data_in = 1'b1;
         end

         if (eol_now) begin
            if (!row_has_data_ff) begin
               // A second empty line in a row is the return-to-control code;
               // the rest of this byte is thrown away.
               if (empty_eol_ff != 2'd0) begin
                  evq_push        = 1'b1;
                  ev.kind         = EV_RTC;
                  zero_run_in     = '0;
                  tag_pending_in  = 1'b0;
                  row_has_data_in = 1'b0;
                  empty_eol_in    = '0;
                  done            = 1'b1;
               end else begin
                  empty_eol_in = empty_eol_ff + 2'd1;
               end
            end else begin
               evq_push = 1'b1;
               ev.kind  = EV_EOL;
               ev.arg   = two_d_mode ? (4'(EOL_CODE_2D) | {3'b000, eol_tag})
                                     : 4'(EOL_CODE_1D);
               row_has_data_in = 1'b0;
               empty_eol_in    = '0;
            end
         end

         idx_in = idx_ff + 3'd1;
         if (done) begin
            busy_in = 1'b0;
         end
      end

      req_ready = !busy_ff || (step && done);
      if (req_valid && req_ready) begin
         busy_in = 1'b1;
         cmd_in  = req_cmd;
         byte_in = req_data_byte;
         idx_in  = '0;
      end

      evq_data = ev;
   end

endmodule

// ----- rtl/fgd_evq.sv -----
// Short event queue between the bit scanner and the row builder.
// Uses fgd_pkg for the entry type and depth.
module fgd_evq import fgd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  evq_entry_type push_data,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output evq_entry_type head
);

   localparam int PTR_W = $clog2(EVQ_DEPTH);
   localparam int CNT_W = $clog2(EVQ_DEPTH + 1);

   evq_entry_type    slot_ff [EVQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   always_comb begin
      full       = (count_ff == CNT_W'(EVQ_DEPTH));
      head_valid = (count_ff != '0);
      head       = slot_ff[rd_ptr_ff];
      do_pop     = pop && head_valid;
      wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/fgd_back.sv -----
// Row builder: packs runs into bytes, collects bit-reversed bytes into 64-bit
// words in the row store, appends the EOL bytes and drains rows and page
// summaries to the response register. Uses fgd_pkg and fgd_ram.
module fgd_back import fgd_pkg::*; #(
   parameter int ROW_BITS = 2432
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          evq_valid,
   input  evq_entry_type evq_head,
   output logic          evq_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_kind,
   output logic [63:0]   rsp_row_word,
   output logic [3:0]    rsp_word_bytes,
   output logic          rsp_last,
   output logic [15:0]   rsp_row_count,
   output logic [23:0]   rsp_total_bytes,
   output logic          rsp_premature_end
);

   localparam int ROW_BYTES = ROW_BITS / 8;
   localparam int DATA_CAP  = ROW_BYTES - 2;
   localparam int FILL_W    = $clog2(ROW_BYTES + 1);
   localparam int WORDS     = (ROW_BYTES + 7) / 8;
   localparam int ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;

   back_state_type    state_ff, state_in;
   logic [3:0]        run_len_ff, run_len_in;
   logic [7:0]        code_ff, code_in;
   logic              prem_ff, prem_in;
   logic [7:0]        pack_byte_ff, pack_byte_in;
   logic [2:0]        pack_bit_ff, pack_bit_in;
   logic [FILL_W-1:0] row_fill_ff, row_fill_in;
   logic [63:0]       acc_ff, acc_in;
   logic [15:0]       rows_ff, rows_in;
   logic [23:0]       bytes_ff, bytes_in;
   logic [FILL_W-1:0] drain_left_ff, drain_left_in;
   logic [ADDR_W-1:0] widx_ff, widx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [63:0] rsp_word_ff, rsp_word_in;
   logic [3:0]  rsp_bytes_ff, rsp_bytes_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [15:0] rsp_rows_ff, rsp_rows_in;
   logic [23:0] rsp_total_ff, rsp_total_in;
   logic        rsp_prem_ff, rsp_prem_in;

   logic              out_free;
   logic              st_en;
   logic              st_force;
   logic [7:0]        st_val;
   logic [2:0]        lane;
   logic [63:0]       acc_new;
   logic [3:0]        avail;
   logic [7:0]        run_byte;
   logic [24:0]       bytes_sum;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [63:0]       ram_wdata;
   logic              ram_re;
   logic [63:0]       ram_rdata;

   fgd_ram #(
      .WIDTH (64),
      .DEPTH (WORDS)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (widx_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         pack_byte_ff <= '0;
         pack_bit_ff  <= 3'd7;
         row_fill_ff  <= '0;
         acc_ff       <= '0;
         rows_ff      <= '0;
         bytes_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pack_byte_ff <= pack_byte_in;
         pack_bit_ff  <= pack_bit_in;
         row_fill_ff  <= row_fill_in;
         acc_ff       <= acc_in;
         rows_ff      <= rows_in;
         bytes_ff     <= bytes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      run_len_ff    <= run_len_in;
      code_ff       <= code_in;
      prem_ff       <= prem_in;
      drain_left_ff <= drain_left_in;
      widx_ff       <= widx_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_rows_ff   <= rsp_rows_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_prem_ff   <= rsp_prem_in;
   end

   always_comb begin
      state_in      = state_ff;
      run_len_in    = run_len_ff;
      code_in       = code_ff;
      prem_in       = prem_ff;
      pack_byte_in  = pack_byte_ff;
      pack_bit_in   = pack_bit_ff;
      row_fill_in   = row_fill_ff;
      acc_in        = acc_ff;
      rows_in       = rows_ff;
      bytes_in      = bytes_ff;
      drain_left_in = drain_left_ff;
      widx_in       = widx_ff;

      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_rows_in  = rsp_rows_ff;
      rsp_total_in = rsp_total_ff;
      rsp_prem_in  = rsp_prem_ff;

      evq_pop   = 1'b0;
      st_en     = 1'b0;
      st_force  = 1'b0;
      st_val    = pack_byte_ff;
      ram_we    = 1'b0;
      ram_waddr = ADDR_W'(row_fill_ff >> 3);
      ram_wdata = acc_ff;
      ram_re    = 1'b0;

      avail     = {1'b0, pack_bit_ff} + 4'd1;
      run_byte  = pack_byte_ff | (8'd1 << (avail - run_len_ff));
      bytes_sum = {1'b0, bytes_ff} + 25'(row_fill_ff);

      case (state_ff)
         BK_IDLE: begin
            if (evq_valid) begin
               evq_pop = 1'b1;
               case (evq_head.kind)
                  EV_RUN: begin
                     run_len_in = evq_head.arg;
                     state_in   = BK_RUN;
                  end
                  EV_EOL: begin
                     code_in  = 8'(evq_head.arg);
                     state_in = BK_PAD;
                  end
                  EV_RTC: begin
                     prem_in  = 1'b0;
                     state_in = BK_SUM;
                  end
                  EV_EOD: begin
                     prem_in  = 1'b1;
                     state_in = BK_SUM;
                  end
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_RUN: begin
            // The run's zeros then its one; a run can cross up to two byte
            // boundaries, and each crossing stores the filled byte.
            if (run_len_ff <= avail) begin
               if (run_len_ff == avail) begin
                  st_en        = 1'b1;
                  st_val       = run_byte;
                  pack_byte_in = '0;
                  pack_bit_in  = 3'd7;
               end else begin
                  pack_byte_in = run_byte;
                  pack_bit_in  = 3'(avail - run_len_ff - 4'd1);
               end
               state_in = BK_IDLE;
            end else begin
               st_en        = 1'b1;
               st_val       = pack_byte_ff;
               pack_byte_in = '0;
               pack_bit_in  = 3'd7;
               run_len_in   = run_len_ff - avail;
            end
         end
         BK_PAD: begin
            if (pack_bit_ff != 3'd7) begin
               st_en  = 1'b1;
               st_val = pack_byte_ff;
            end
            pack_byte_in = '0;
            pack_bit_in  = 3'd7;
            state_in     = BK_EOL_LO;
         end
         BK_EOL_LO: begin
            st_en    = 1'b1;
            st_force = 1'b1;
            st_val   = EOL_FIRST_BYTE;
            state_in = BK_EOL_HI;
         end
         BK_EOL_HI: begin
            st_en    = 1'b1;
            st_force = 1'b1;
            st_val   = code_ff;
            state_in = BK_FLUSH;
         end
         BK_FLUSH: begin
            if (row_fill_ff[2:0] != 3'd0) begin
               ram_we = 1'b1;
            end
            acc_in = '0;
            if (rows_ff != ROW_COUNT_MAX) begin
               rows_in = rows_ff + 16'd1;
            end
            bytes_in      = bytes_sum[24] ? BYTE_COUNT_MAX : bytes_sum[23:0];
            drain_left_in = row_fill_ff;
            widx_in       = '0;
            state_in      = BK_DRAIN_RD;
         end
         BK_DRAIN_RD: begin
            ram_re   = 1'b1;
            state_in = BK_DRAIN_WAIT;
         end
         BK_DRAIN_WAIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = RSP_KIND_ROW;
               rsp_word_in  = ram_rdata;
               rsp_bytes_in = (drain_left_ff > FILL_W'(8)) ? 4'd8 : 4'(drain_left_ff);
               rsp_last_in  = (drain_left_ff <= FILL_W'(8));
               rsp_rows_in  = rows_ff;
               rsp_total_in = bytes_ff;
               rsp_prem_in  = 1'b0;
               if (drain_left_ff <= FILL_W'(8)) begin
                  row_fill_in = '0;
                  state_in    = BK_IDLE;
               end else begin
                  drain_left_in = drain_left_ff - FILL_W'(8);
                  widx_in       = widx_ff + 1'b1;
                  state_in      = BK_DRAIN_RD;
               end
            end
         end
         BK_SUM: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = RSP_KIND_SUMMARY;
               rsp_word_in  = '0;
               rsp_bytes_in = '0;
               rsp_last_in  = 1'b1;
               rsp_rows_in  = rows_ff;
               rsp_total_in = bytes_ff;
               rsp_prem_in  = prem_ff;
               rows_in      = '0;
               bytes_in     = '0;
               row_fill_in  = '0;
               acc_in       = '0;
               pack_byte_in = '0;
               pack_bit_in  = 3'd7;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase

      // Byte store: data bytes stop at the cap so the two EOL bytes always fit.
      lane    = row_fill_ff[2:0];
      acc_new = acc_ff | (64'(rev8(st_val)) << {lane, 3'b000});
      if (st_en && (st_force || (row_fill_ff < FILL_W'(DATA_CAP)))) begin
         row_fill_in = row_fill_ff + 1'b1;
         if (lane == 3'd7) begin
            ram_we    = 1'b1;
            ram_wdata = acc_new;
            acc_in    = '0;
         end else begin
            acc_in = acc_new;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_row_word      = rsp_word_ff;
   assign rsp_word_bytes    = rsp_bytes_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_row_count     = rsp_rows_ff;
   assign rsp_total_bytes   = rsp_total_ff;
   assign rsp_premature_end = rsp_prem_ff;

endmodule

// ----- rtl/fax_g3_eol_row_deframer.sv -----
// Data bytes are scanned at one line bit per cycle while the event queue has room, and
// the next beat is accepted as the last bit of a byte is scanned. A row's first word
// and an RTC or end-of-data summary go out once queued run work is done and the
// output is free; the builder's backlog stalls input. Reset is synchronous, active
// high, and clears all control state and page counters; the row store is not cleared
// and needs no pass.
module fax_g3_eol_row_deframer import fgd_pkg::*; #(
   parameter int ROW_BITS = 2432
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [63:0] rsp_row_word,
   output logic [3:0]  rsp_word_bytes,
   output logic        rsp_last,
   output logic [15:0] rsp_row_count,
   output logic [23:0] rsp_total_bytes,
   output logic        rsp_premature_end
);

   logic          two_d_mode_ff;
   logic          evq_push;
   logic          evq_full;
   logic          evq_pop;
   logic          evq_valid;
   evq_entry_type evq_push_data;
   evq_entry_type evq_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         two_d_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         two_d_mode_ff <= csr_wr_data;
      end
   end

   fgd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .two_d_mode    (two_d_mode_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .evq_full      (evq_full),
      .evq_push      (evq_push),
      .evq_data      (evq_push_data)
   );

   fgd_evq u_evq (
      .clock      (clock),
      .reset      (reset),
      .push       (evq_push),
      .push_data  (evq_push_data),
      .full       (evq_full),
      .pop        (evq_pop),
      .head_valid (evq_valid),
      .head       (evq_head)
   );

   fgd_back #(
      .ROW_BITS (ROW_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .evq_valid         (evq_valid),
      .evq_head          (evq_head),
      .evq_pop           (evq_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_row_word      (rsp_row_word),
      .rsp_word_bytes    (rsp_word_bytes),
      .rsp_last          (rsp_last),
      .rsp_row_count     (rsp_row_count),
      .rsp_total_bytes   (rsp_total_bytes),
      .rsp_premature_end (rsp_premature_end)
   );

`ifndef SYNTHESIS
   // The scanner must never push an event into a full queue.
   a_evq_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(evq_push && evq_full))
      else $error("event pushed into full queue");

   // A page summary carries no row bytes and always closes its group.
   a_summary_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == RSP_KIND_SUMMARY) |->
         (rsp_last && rsp_word_bytes == 4'd0 && rsp_row_word == 64'd0))
      else $error("malformed page summary");

   // Row words hold between one and eight bytes.
   a_row_word_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == RSP_KIND_ROW) |->
         (rsp_word_bytes != 4'd0 && rsp_word_bytes <= 4'd8))
      else $error("row word byte count out of range");

   // A row word that is not the last of its row is always full.
   a_row_word_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == RSP_KIND_ROW && !rsp_last) |->
         (rsp_word_bytes == 4'd8))
      else $error("short row word before end of row");
`endif

endmodule
